[design/length_prefixed_frame_deframer_unit_macros.svh]
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer: assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define LPFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpfd assertion failed");

// next-cycle implication
`define LPFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpfd assertion failed");

`endif

[design/lpfd_pkg.sv]
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfd_pkg;

  localparam int unsigned HARD_PAYLOAD_LIMIT = 1048576;
  localparam logic [31:0] HARD_LIMIT = 32'(HARD_PAYLOAD_LIMIT);

  localparam int LEN_W = 32;
  localparam int CFG_W = 21;
  localparam int REM_W = 21;

  localparam logic [7:0] MAGIC_HI = 8'h56;
  localparam logic [7:0] MAGIC_LO = 8'h54;
  localparam logic [7:0] VERSION  = 8'h01;

  localparam logic [7:0] KIND_TEXT   = 8'd1;
  localparam logic [7:0] KIND_BINARY = 8'd2;
  localparam logic [7:0] KIND_CLOSE  = 8'd3;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  localparam logic [1:0] EV_DATA  = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_CLOSE = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  localparam logic [2:0] HDR_LEN0 = 3'd4;
  localparam logic [2:0] HDR_LAST = 3'd7;

  typedef struct packed {
    logic [1:0]       phase;
    logic [2:0]       hdr_idx;
    logic             hdr_good;
    logic [7:0]       kind;
    logic [LEN_W-1:0] len_acc;
    logic [REM_W-1:0] remaining;
  } lpfd_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] event_res;
    logic [7:0] payload_byte;
    logic       is_text;
    logic       last_of_message;
  } lpfd_result_t;

  function automatic lpfd_state_t lpfd_state_init();
    lpfd_state_t s;
    s.phase     = PH_HEADER;
    s.hdr_idx   = '0;
    s.hdr_good  = 1'b1;
    s.kind      = '0;
    s.len_acc   = '0;
    s.remaining = '0;
    return s;
  endfunction

endpackage

`default_nettype wire

[design/length_prefixed_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_unit
// Splits a byte stream into length-prefixed frames and reports their contents.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_stream_byte) takes one stream
//   word per cycle while in_stall is low. Each word gives zero or one result
//   word on the output channel (out_valid / out_stall / out_event_res,
//   out_payload_byte, out_is_text, out_last_of_message).
//   A result appears on the output register in the cycle after its input
//   word is accepted. Throughput is one word per cycle while the receiver
//   does not stall, set by the combinational header/payload decode feeding
//   the output register.
//   The configuration channel (cfg_valid / cfg_ready / cfg_max_payload) is
//   always ready; write it only while the block is idle.
//   Reset (rst_n low, synchronous) returns the decoder to the header phase
//   and sets the payload limit to one mebibyte.
//   When the receiver stalls with a result pending, in_stall rises and the
//   pending result holds until taken; an unstalled output register accepts
//   a new word in the same cycle its old result leaves.
//   After a close or error every further word is taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_deframer_unit import lpfd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_stream_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_event_res,
  output logic [7:0]            out_payload_byte,
  output logic                  out_is_text,
  output logic                  out_last_of_message,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_max_payload
);

  lpfd_state_t      st_r;
  lpfd_state_t      st_nxt;
  lpfd_result_t     res;
  lpfd_result_t     out_r;
  logic [CFG_W-1:0] max_payload_r;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_r.valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  lpfd_core u_core (
    .st          (st_r),
    .byte_in     (in_stream_byte),
    .max_payload (max_payload_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= CFG_W'(HARD_PAYLOAD_LIMIT);
    end else if (cfg_valid) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lpfd_state_init();
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (accept) begin
      out_r <= res;
    end else if (!out_stall) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_valid           = out_r.valid;
  assign out_event_res       = out_r.event_res;
  assign out_payload_byte    = out_r.payload_byte;
  assign out_is_text         = out_r.is_text;
  assign out_last_of_message = out_r.last_of_message;

endmodule

`default_nettype wire

[design/lpfd_core.sv]
// ----------------------------------------------------------------------------
// lpfd_core
// Per-byte next-state and result logic of the frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_core import lpfd_pkg::*; (
  input  lpfd_state_t      st,
  input  logic [7:0]       byte_in,
  input  logic [CFG_W-1:0] max_payload,
  output lpfd_state_t      st_nxt,
  output lpfd_result_t     res
);

  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] len_new;
  logic             good_new;
  logic [7:0]       kind_new;
  logic             is_msg;
  logic             last;

  always_comb begin
    if (LEN_W'(max_payload) > HARD_LIMIT) begin
      limit = HARD_LIMIT;
    end else begin
      limit = LEN_W'(max_payload);
    end
  end

  always_comb begin
    st_nxt   = st;
    res      = '0;
    good_new = st.hdr_good;
    kind_new = st.kind;
    len_new  = st.len_acc;
    is_msg   = (st.kind == KIND_TEXT) || (st.kind == KIND_BINARY);
    last     = (st.remaining <= REM_W'(1));
    unique case (st.phase)
      PH_HEADER: begin
        unique case (st.hdr_idx)
          3'd0: good_new = st.hdr_good & (byte_in == MAGIC_HI);
          3'd1: good_new = st.hdr_good & (byte_in == MAGIC_LO);
          3'd2: good_new = st.hdr_good & (byte_in == VERSION);
          3'd3: kind_new = byte_in;
          default: len_new = {st.len_acc[LEN_W-9:0], byte_in};
        endcase
        st_nxt.hdr_good = good_new;
        st_nxt.kind     = kind_new;
        st_nxt.len_acc  = len_new;
        is_msg = (kind_new == KIND_TEXT) || (kind_new == KIND_BINARY);
        if (st.hdr_idx != HDR_LAST) begin
          st_nxt.hdr_idx = st.hdr_idx + 3'd1;
        end else if (!good_new || (len_new > limit)) begin
          st_nxt.phase  = PH_DONE;
          res.valid     = 1'b1;
          res.event_res = EV_ERROR;
        end else if (len_new == '0) begin
          res.valid = 1'b1;
          if (is_msg) begin
            st_nxt              = lpfd_state_init();
            res.event_res       = EV_EMPTY;
            res.is_text         = (kind_new == KIND_TEXT);
            res.last_of_message = 1'b1;
          end else begin
            st_nxt.phase  = PH_DONE;
            res.event_res = (kind_new == KIND_CLOSE) ? EV_CLOSE : EV_ERROR;
          end
        end else begin
          st_nxt.remaining = len_new[REM_W-1:0];
          st_nxt.hdr_idx   = '0;
          st_nxt.phase     = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (st.remaining != '0) begin
          st_nxt.remaining = st.remaining - REM_W'(1);
        end
        if (is_msg) begin
          res.valid           = 1'b1;
          res.event_res       = EV_DATA;
          res.payload_byte    = byte_in;
          res.is_text         = (st.kind == KIND_TEXT);
          res.last_of_message = last;
          if (last) begin
            st_nxt = lpfd_state_init();
          end
        end else if (last) begin
          st_nxt.phase  = PH_DONE;
          res.valid     = 1'b1;
          res.event_res = (st.kind == KIND_CLOSE) ? EV_CLOSE : EV_ERROR;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[design/lpfd_checker.sv]
// ----------------------------------------------------------------------------
// lpfd_checker
// Port-level assertions for the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_prefixed_frame_deframer_unit_macros.svh"

module lpfd_checker import lpfd_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic [7:0]       in_stream_byte,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [1:0]       out_event_res,
  input wire logic [7:0]       out_payload_byte,
  input wire logic             out_is_text,
  input wire logic             out_last_of_message,
  input wire logic             cfg_valid,
  input wire logic             cfg_ready,
  input wire logic [CFG_W-1:0] cfg_max_payload
);

  logic unused_ok;
  assign unused_ok = ^{in_valid, in_stream_byte, cfg_valid, cfg_ready, cfg_max_payload};

  `LPFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_event_res) && $stable(out_payload_byte) && $stable(out_is_text) && $stable(out_last_of_message))

  `LPFD_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall)

  `LPFD_ASSERT_NOW(a_data_zero, out_valid && (out_event_res != EV_DATA), out_payload_byte == 8'd0)

  `LPFD_ASSERT_NOW(a_end_flags, out_valid && ((out_event_res == EV_CLOSE) || (out_event_res == EV_ERROR)), !out_is_text && !out_last_of_message)

  `LPFD_ASSERT_NOW(a_empty_last, out_valid && (out_event_res == EV_EMPTY), out_last_of_message)

endmodule

bind length_prefixed_frame_deframer_unit lpfd_checker u_lpfd_checker (.*);

`default_nettype wire
